FILE: hdl/multichannel_moving_average_macros.svh
// -----------------------------------------------------------------------------
// Multichannel moving average assertion macros
// Short forms for the clocked, reset-qualified properties of the checker.
// -----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average check failed");

`endif

FILE: hdl/mma_pkg.sv
// -----------------------------------------------------------------------------
// Multichannel moving average package
// Sizes, derived widths and the per-channel state word.
// -----------------------------------------------------------------------------
package mma_pkg;

    localparam int WINDOW     = 16;
    localparam int CHANNELS   = 48;

    localparam int CHAN_W     = 6;
    localparam int SAMPLE_W   = 24;
    localparam int TDATA_W    = 32;

    localparam int WIN_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int DIV_CW     = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        fill;
        logic [WIN_W-1:0]        oldest;
    } t_chan_state;

endpackage

FILE: hdl/multichannel_moving_average.sv
// -----------------------------------------------------------------------------
// Multichannel moving average
// Per-channel sliding window mean of signed Q15.8 samples, bit-serial divide.
// -----------------------------------------------------------------------------
//  Stream | Direction | Fields                              | Taken when
//  s_axis | in        | channel, sample                     | the block is idle
//  m_axis | out       | out_channel, average; window_full   | the output register is full
//
// An in-range word passes through the ring address, ring load, subtract, add, absolute value
// and divide states before its result loads into the output register; the restoring divider
// works out one quotient bit per cycle. A channel number out of range goes straight to the
// result state with a zero average; either way the next word waits until the result loads.
// Reset clears the per-channel valid bits at once; no clearing pass is run.
// While an untaken result sits in the output register, the next result waits in the divider.
// -----------------------------------------------------------------------------
module multichannel_moving_average
    import mma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // channel[5:0], sample[29:6], zero pad
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,  // out_channel[5:0], average[29:6], zero pad
    output logic               o_m_axis_tuser   // window_full[0]
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_RING = 8'b00000010,
        S_LOAD = 8'b00000100,
        S_SUB  = 8'b00001000,
        S_ADD  = 8'b00010000,
        S_ABS  = 8'b00100000,
        S_DIV  = 8'b01000000,
        S_FIN  = 8'b10000000
    } t_state;

    t_state r_state;

    // Storage.
    t_chan_state               st_mem [CHANNELS];
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [CHANNELS-1:0]       r_st_valid;

    // Item registers.
    logic [CHAN_W-1:0]          r_chan;
    logic signed [SAMPLE_W-1:0] r_sample;
    t_chan_state                r_rd_state;
    logic                       r_rd_valid;
    logic [RING_AW-1:0]         r_addr;
    logic signed [SAMPLE_W-1:0] r_old;
    logic                       r_was_full;
    logic [CNT_W-1:0]           r_fill_new;
    logic [WIN_W-1:0]           r_oldest_new;
    logic                       r_full_new;
    logic signed [SUM_W-1:0]    r_sum;

    // Divider shift registers.
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_neg;

    // Output register.
    logic                       r_out_valid;
    logic [CHAN_W-1:0]          r_out_chan;
    logic signed [SAMPLE_W-1:0] r_out_avg;
    logic                       r_out_full;

    logic                    in_accept;
    logic                    in_range;
    logic [CH_IDX_W-1:0]     ch_idx;
    t_chan_state             cur;
    logic                    cur_full;
    logic [CNT_W:0]          pos_sum;
    logic [WIN_W-1:0]        n_pos;
    logic [CNT_W-1:0]        n_fill;
    logic [WIN_W-1:0]        n_oldest;
    logic [RING_AW-1:0]      n_addr;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W:0]          div_shift;
    logic                    div_bit;
    logic [CNT_W-1:0]        n_rem;
    logic                    out_load;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_range  = {26'd0, i_s_axis_tdata[CHAN_W-1:0]} < 32'(CHANNELS);
    assign ch_idx    = CH_IDX_W'(r_chan);

    // A channel never written since reset reads as all zero.
    assign cur      = r_rd_valid ? r_rd_state : '0;
    assign cur_full = cur.fill >= CNT_W'(WINDOW);

    always_comb begin
        pos_sum  = (CNT_W+1)'(cur.oldest) + (CNT_W+1)'(cur.fill);
        n_pos    = cur.oldest;
        n_fill   = cur.fill;
        n_oldest = cur.oldest;
        if (!cur_full) begin
            if (pos_sum >= (CNT_W+1)'(WINDOW)) begin
                n_pos = WIN_W'(pos_sum - (CNT_W+1)'(WINDOW));
            end else begin
                n_pos = WIN_W'(pos_sum);
            end
            n_fill = cur.fill + CNT_W'(1);
        end else if (cur.oldest == WIN_W'(WINDOW - 1)) begin
            n_oldest = '0;
        end else begin
            n_oldest = cur.oldest + WIN_W'(1);
        end
        n_addr = RING_AW'(ch_idx) * RING_AW'(WINDOW) + RING_AW'(n_pos);
    end

    assign n_sum = r_sum + SUM_W'(r_sample);

    // One restoring divide step: shift in the next dividend bit and try the divisor.
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_bit   = div_shift >= {1'b0, r_fill_new};
    assign n_rem     = div_bit ? CNT_W'(div_shift - {1'b0, r_fill_new}) : CNT_W'(div_shift);

    assign out_load  = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_st_valid <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= in_range ? S_RING : S_FIN;
                    end
                end
                S_RING: r_state <= S_LOAD;
                S_LOAD: r_state <= S_SUB;
                S_SUB:  r_state <= S_ADD;
                S_ADD: begin
                    r_st_valid[ch_idx] <= 1'b1;
                    r_state            <= S_ABS;
                end
                S_ABS:  r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_chan     <= i_s_axis_tdata[CHAN_W-1:0];
                r_sample   <= i_s_axis_tdata[CHAN_W +: SAMPLE_W];
                r_quo      <= '0;
                r_neg      <= 1'b0;
                r_full_new <= 1'b0;
            end
            S_RING: begin
                r_addr       <= n_addr;
                r_was_full   <= cur_full;
                r_fill_new   <= n_fill;
                r_oldest_new <= n_oldest;
                r_full_new   <= n_fill >= CNT_W'(WINDOW);
                r_sum        <= cur.sum;
            end
            S_SUB: begin
                if (r_was_full) begin
                    r_sum <= r_sum - SUM_W'(r_old);
                end
            end
            S_ADD: begin
                r_sum <= n_sum;
            end
            S_ABS: begin
                r_neg <= r_sum[SUM_W-1];
                r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                r_rem <= '0;
                r_cnt <= DIV_CW'(SUM_W - 1);
            end
            S_DIV: begin
                r_quo <= {r_quo[SUM_W-2:0], div_bit};
                r_rem <= n_rem;
                r_cnt <= r_cnt - DIV_CW'(1);
            end
            default: ;
        endcase
    end

    // Per-channel state memory: read on acceptance, written back with the new sum.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_state <= st_mem[CH_IDX_W'(i_s_axis_tdata[CHAN_W-1:0])];
            r_rd_valid <= r_st_valid[CH_IDX_W'(i_s_axis_tdata[CHAN_W-1:0])];
        end
        if (r_state == S_ADD) begin
            st_mem[ch_idx] <= '{sum: n_sum, fill: r_fill_new, oldest: r_oldest_new};
        end
    end

    // Sample ring: the old entry is read in the same cycle the new sample replaces it.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            ring_mem[r_addr] <= r_sample;
            r_old            <= ring_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_chan <= r_chan;
            r_out_avg  <= r_neg ? -r_quo[SAMPLE_W-1:0] : r_quo[SAMPLE_W-1:0];
            r_out_full <= r_full_new;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(TDATA_W - CHAN_W - SAMPLE_W)'(0), r_out_avg, r_out_chan};
    assign o_m_axis_tuser  = r_out_full;

endmodule

FILE: hdl/mma_checker.sv
// -----------------------------------------------------------------------------
// Multichannel moving average port checker
// Watches the stream ports of the top level over time.
// -----------------------------------------------------------------------------
`include "multichannel_moving_average_macros.svh"

module mma_checker
    import mma_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic [TDATA_W-1:0] i_s_axis_tdata,  // channel[5:0], sample[29:6], zero pad
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata,  // out_channel[5:0], average[29:6], zero pad
    input logic               o_m_axis_tuser   // window_full[0]
);

    logic out_of_range;

    assign out_of_range = {26'd0, o_m_axis_tdata[CHAN_W-1:0]} >= 32'(CHANNELS);

    // The block works on one word at a time.
    `MMA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // A result that is not taken stays put.
    `MMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // An unknown channel reports a zero mean and no full window.
    `MMA_ASSERT_IMPLY(a_bad_channel, i_clk, i_rst_n, o_m_axis_tvalid && out_of_range, o_m_axis_tdata[CHAN_W +: SAMPLE_W] == '0 && !o_m_axis_tuser)

    // A new result is loaded only while the input side is busy.
    `MMA_ASSERT_IMPLY(a_load_when_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (.*);

FILE: dv/multichannel_moving_average_test.sv
// -----------------------------------------------------------------------------
// Multichannel moving average testbench
// Drives channel/sample words through the input stream and checks every result
// word against a per-channel sliding window predictor. A short directed table
// covers field extremes, out-of-range channels, truncation toward zero and a
// window wrap. Random traffic follows, with random gaps on both streams, a long
// output hold-off and a full drain in the middle of the run.
// -----------------------------------------------------------------------------
module multichannel_moving_average_test;
    import mma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS    = 925;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] avg;
        logic                       full;
    } t_mean;

    typedef struct {
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] avg;
        bit                         full;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [TDATA_W-1:0] i_s_axis_tdata;   // channel[5:0], sample[29:6], zero pad
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [TDATA_W-1:0] o_m_axis_tdata;   // out_channel[5:0], average[29:6], zero pad
    logic               o_m_axis_tuser;   // window_full[0]

    // Predictor state, one window per channel.
    logic signed [SAMPLE_W-1:0] hist [CHANNELS][WINDOW];
    longint                     run_total [CHANNELS];
    int                         fill_depth [CHANNELS];
    int                         head [CHANNELS];

    t_mean    mean_queue[$];
    t_dir_row directed_rows[$];
    int       mismatch_count;
    bit       calm;
    bit       hold_off_go;
    t_mean    want;
    logic [CHAN_W-1:0]          got_chan;
    logic signed [SAMPLE_W-1:0] got_avg;

    multichannel_moving_average u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_mean predict_mean(input logic [CHAN_W-1:0] chan,
                                           input logic signed [SAMPLE_W-1:0] smp);
        t_mean r;
        int    c;
        int    slot;
        r.chan = chan;
        r.avg  = '0;
        r.full = 1'b0;
        if (chan >= CHANNELS) begin
            return r;
        end
        c = int'(chan);
        if (fill_depth[c] < WINDOW) begin
            slot = (head[c] + fill_depth[c]) % WINDOW;
            hist[c][slot] = smp;
            run_total[c] += smp;
            fill_depth[c]++;
        end else begin
            // Full window: the oldest sample leaves and the head moves on.
            slot = head[c];
            run_total[c] -= hist[c][slot];
            hist[c][slot] = smp;
            run_total[c] += smp;
            head[c] = (slot + 1) % WINDOW;
        end
        r.avg  = SAMPLE_W'(run_total[c] / fill_depth[c]);
        r.full = (fill_depth[c] >= WINDOW);
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return SAMPLE_MIN;
            end
            1: begin
                return SAMPLE_MAX;
            end
            2: begin
                return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
            end
            default: begin
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    function automatic void add_row(input logic [CHAN_W-1:0] chan,
                                    input logic signed [SAMPLE_W-1:0] smp, input bit typed,
                                    input logic signed [SAMPLE_W-1:0] avg, input bit full);
        t_dir_row row;
        row.chan  = chan;
        row.smp   = smp;
        row.typed = typed;
        row.avg   = avg;
        row.full  = full;
        directed_rows.push_back(row);
    endfunction

    task automatic send_word(input logic [CHAN_W-1:0] chan,
                             input logic signed [SAMPLE_W-1:0] smp, input bit typed,
                             input logic signed [SAMPLE_W-1:0] typed_avg, input bit typed_full);
        t_mean exp_word;
        int    gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(TDATA_W-CHAN_W-SAMPLE_W){1'b0}}, smp, chan};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        exp_word = predict_mean(chan, smp);
        if (typed) begin
            exp_word.avg  = typed_avg;
            exp_word.full = typed_full;
        end
        mean_queue.push_back(exp_word);
        gap = gap_len();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The input goes idle first, so the last word is not offered a second time.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (mean_queue.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result checker: samples at the edge, before the block's outputs move.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_chan = o_m_axis_tdata[CHAN_W-1:0];
            got_avg  = o_m_axis_tdata[CHAN_W +: SAMPLE_W];
            if (mean_queue.size() == 0) begin
                $display("%0t: unexpected word: channel %0d average %0d full %0b",
                         $time, got_chan, got_avg, o_m_axis_tuser);
                mismatch_count++;
            end else begin
                want = mean_queue.pop_front();
                if (got_chan !== want.chan) begin
                    $display("%0t: out_channel expected %0d actual %0d",
                             $time, want.chan, got_chan);
                    mismatch_count++;
                end
                if (got_avg !== want.avg) begin
                    $display("%0t: average (channel %0d) expected %0d actual %0d",
                             $time, want.chan, want.avg, got_avg);
                    mismatch_count++;
                end
                if (o_m_axis_tuser !== want.full) begin
                    $display("%0t: window_full (channel %0d) expected %0b actual %0b",
                             $time, want.chan, want.full, o_m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off while words keep coming.
    initial begin : drain_side
        bit held;
        int stall;
        held = 1'b0;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_off_go && !held) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            stall = gap_len();
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) begin
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [CHAN_W-1:0] hot [4];
        int                r;
        int                hold_at;
        int                drain_at;
        logic [CHAN_W-1:0] chan;

        mismatch_count = 0;
        calm           = 1'b0;
        hold_off_go    = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            run_total[c]  = 0;
            fill_depth[c] = 0;
            head[c]       = 0;
            for (int k = 0; k < WINDOW; k++) begin
                hist[c][k] = '0;
            end
        end

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First word of a channel averages to itself; odd sums truncate toward zero.
        add_row(6'd0,  SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b0);
        add_row(6'd0,  SAMPLE_MIN, 1'b1, '0,         1'b0);
        add_row(6'd47, SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b0);
        add_row(6'd48, 24'sd12345, 1'b1, '0,         1'b0);
        add_row(6'd63, -24'sd1,    1'b1, '0,         1'b0);
        add_row(6'd1,  -24'sd1,    1'b1, -24'sd1,    1'b0);
        add_row(6'd1,  24'sd0,     1'b1, '0,         1'b0);
        add_row(6'd1,  -24'sd2,    1'b1, -24'sd1,    1'b0);
        // Fill one channel to the brim, then push it past the wrap.
        for (int k = 0; k < WINDOW; k++) begin
            add_row(6'd5, SAMPLE_MIN, 1'b1, SAMPLE_MIN, k == WINDOW - 1);
        end
        add_row(6'd5, SAMPLE_MAX, 1'b0, '0, 1'b0);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].chan, directed_rows[i].smp, directed_rows[i].typed,
                      directed_rows[i].avg, directed_rows[i].full);
        end

        hold_at  = $urandom_range(200, 350);
        drain_at = $urandom_range(650, 800);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // A few hot channels at a time, so windows fill and wrap often.
            if (n % 100 == 0) begin
                foreach (hot[k]) begin
                    hot[k] = CHAN_W'($urandom_range(0, CHANNELS - 1));
                end
            end
            calm = (n >= 500 && n < 600);
            if (n == hold_at) begin
                hold_off_go = 1'b1;
            end
            if (n == drain_at) begin
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                chan = hot[$urandom_range(0, 3)];
            end else if (r < 90) begin
                chan = CHAN_W'($urandom_range(0, CHANNELS - 1));
            end else begin
                chan = CHAN_W'($urandom_range(CHANNELS, 63));
            end
            send_word(chan, rand_sample(), 1'b0, '0, 1'b0);
        end
        i_s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("multichannel_moving_average regression: pass");
        end else begin
            $display("multichannel_moving_average regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("multichannel_moving_average regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/mma_pkg.sv
hdl/multichannel_moving_average.sv
hdl/mma_checker.sv
dv/multichannel_moving_average_test.sv
